// ===== rtl/core/olrb_pkg.sv =====
`timescale 1ns / 1ps

package olrb_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int PTR_W        = $clog2(BUFFER_DEPTH);
   localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
   localparam int BYTE_W       = 8;
   localparam int LIMIT_W      = 16;
   localparam int COUNT_W      = 6;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 16;

   localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [BYTE_W-1:0] NUL_CODE     = 8'h00;

   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SKIP_RD,
      ST_SKIP_CHK,
      ST_CLAMP,
      ST_DATA_RD,
      ST_DATA_OUT,
      ST_TERM
   } state_type;

   typedef struct packed {
      logic do_put;
      logic start_read;
      logic issue_rd;
      logic skip_upd;
      logic clamp;
      logic load_err;
      logic load_data;
      logic load_term;
   } cmd_type;

   typedef struct packed {
      logic limit_zero;
      logic store_full;
      logic rd_is_nl;
      logic avail_last;
      logic remain_zero;
      logic remain_last;
      logic out_free;
   } stat_type;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(BUFFER_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/olrb_ctrl.sv =====
`timescale 1ns / 1ps

module olrb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_type,
   output logic               req_tready,
   input  olrb_pkg::stat_type stat,
   output olrb_pkg::cmd_type  cmd
);

   olrb_pkg::state_type state_ff;
   olrb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= olrb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         olrb_pkg::ST_IDLE: begin
            if (req_tvalid && req_type == olrb_pkg::REQ_READ) begin
               state_in = olrb_pkg::ST_START;
            end
         end
         olrb_pkg::ST_START: begin
            if (stat.limit_zero) begin
               if (stat.out_free) begin
                  state_in = olrb_pkg::ST_IDLE;
               end
            end else if (stat.store_full) begin
               state_in = olrb_pkg::ST_SKIP_RD;
            end else begin
               state_in = olrb_pkg::ST_CLAMP;
            end
         end
         olrb_pkg::ST_SKIP_RD: begin
            state_in = olrb_pkg::ST_SKIP_CHK;
         end
         olrb_pkg::ST_SKIP_CHK: begin
            if (stat.rd_is_nl || stat.avail_last) begin
               state_in = olrb_pkg::ST_CLAMP;
            end else begin
               state_in = olrb_pkg::ST_SKIP_RD;
            end
         end
         olrb_pkg::ST_CLAMP: begin
            state_in = olrb_pkg::ST_DATA_RD;
         end
         olrb_pkg::ST_DATA_RD: begin
            if (stat.remain_zero) begin
               state_in = olrb_pkg::ST_TERM;
            end else begin
               state_in = olrb_pkg::ST_DATA_OUT;
            end
         end
         olrb_pkg::ST_DATA_OUT: begin
            if (stat.out_free && stat.remain_last) begin
               state_in = olrb_pkg::ST_TERM;
            end
         end
         olrb_pkg::ST_TERM: begin
            if (stat.out_free) begin
               state_in = olrb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = olrb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         olrb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_type == olrb_pkg::REQ_PUT) begin
                  cmd.do_put = 1'b1;
               end else begin
                  cmd.start_read = 1'b1;
               end
            end
         end
         olrb_pkg::ST_START: begin
            cmd.load_err = stat.limit_zero && stat.out_free;
         end
         olrb_pkg::ST_SKIP_RD: begin
            cmd.issue_rd = 1'b1;
         end
         olrb_pkg::ST_SKIP_CHK: begin
            cmd.skip_upd = 1'b1;
         end
         olrb_pkg::ST_CLAMP: begin
            cmd.clamp = 1'b1;
         end
         olrb_pkg::ST_DATA_RD: begin
            cmd.issue_rd = !stat.remain_zero;
         end
         olrb_pkg::ST_DATA_OUT: begin
            cmd.load_data = stat.out_free;
            cmd.issue_rd  = stat.out_free && !stat.remain_last;
         end
         olrb_pkg::ST_TERM: begin
            cmd.load_term = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/core/olrb_datapath.sv =====
`timescale 1ns / 1ps

module olrb_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [olrb_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  olrb_pkg::cmd_type                   cmd,
   output olrb_pkg::stat_type                  stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [olrb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tuser
);

   logic [olrb_pkg::BYTE_W-1:0]  log_store_ff [olrb_pkg::BUFFER_DEPTH];
   logic [olrb_pkg::BYTE_W-1:0]  rd_data_ff;

   logic [olrb_pkg::PTR_W-1:0]   oldest_ff, oldest_in;
   logic [olrb_pkg::PTR_W-1:0]   wr_pos_ff, wr_pos_in;
   logic [olrb_pkg::CNT_W-1:0]   fill_ff, fill_in;
   logic                         init_nl_ff, init_nl_in;
   logic                         out_valid_ff, out_valid_in;

   logic [olrb_pkg::PTR_W-1:0]   cur_ff;
   logic [olrb_pkg::CNT_W-1:0]   avail_ff;
   logic [olrb_pkg::CNT_W-1:0]   remain_ff;
   logic [olrb_pkg::COUNT_W-1:0] sent_ff;
   logic [olrb_pkg::LIMIT_W-1:0] limit_ff;

   logic [olrb_pkg::BYTE_W-1:0]  out_byte_ff;
   logic                         out_last_ff;
   logic                         out_status_ff;
   logic [olrb_pkg::COUNT_W-1:0] out_count_ff;

   logic [olrb_pkg::BYTE_W-1:0]  put_byte;
   logic [olrb_pkg::LIMIT_W-1:0] read_limit;
   logic [olrb_pkg::LIMIT_W-1:0] limit_m1;
   logic                         store_full;
   logic                         out_free;

   assign put_byte   = req_tdata[olrb_pkg::BYTE_W-1:0];
   assign read_limit = req_tdata[olrb_pkg::BYTE_W +: olrb_pkg::LIMIT_W];
   assign limit_m1   = limit_ff - olrb_pkg::LIMIT_W'(1);
   assign store_full = (fill_ff == olrb_pkg::CNT_W'(olrb_pkg::BUFFER_DEPTH));
   assign out_free   = !out_valid_ff || rsp_tready;

   assign stat.limit_zero  = (limit_ff == '0);
   assign stat.store_full  = store_full;
   assign stat.rd_is_nl    = (rd_data_ff == olrb_pkg::NEWLINE_CODE);
   assign stat.avail_last  = (avail_ff == olrb_pkg::CNT_W'(1));
   assign stat.remain_zero = (remain_ff == '0);
   assign stat.remain_last = (remain_ff == olrb_pkg::CNT_W'(1));
   assign stat.out_free    = out_free;

   // ring state
   always_comb begin
      oldest_in  = oldest_ff;
      wr_pos_in  = wr_pos_ff;
      fill_in    = fill_ff;
      init_nl_in = init_nl_ff;
      if (cmd.do_put) begin
         wr_pos_in = olrb_pkg::advance(wr_pos_ff);
         if (wr_pos_ff == '0) begin
            init_nl_in = 1'b0;
         end
         if (store_full) begin
            oldest_in = olrb_pkg::advance(oldest_ff);
         end else begin
            fill_in = fill_ff + olrb_pkg::CNT_W'(1);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_err || cmd.load_data || cmd.load_term) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         wr_pos_ff    <= olrb_pkg::PTR_W'(1);
         fill_ff      <= olrb_pkg::CNT_W'(1);
         init_nl_ff   <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         oldest_ff    <= oldest_in;
         wr_pos_ff    <= wr_pos_in;
         fill_ff      <= fill_in;
         init_nl_ff   <= init_nl_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // log memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.do_put) begin
         log_store_ff[wr_pos_ff] <= put_byte;
      end
      if (cmd.issue_rd) begin
         if (init_nl_ff && cur_ff == '0) begin
            rd_data_ff <= olrb_pkg::NEWLINE_CODE;
         end else begin
            rd_data_ff <= log_store_ff[cur_ff];
         end
      end
   end

   // read walk
   always_ff @(posedge clock) begin
      if (cmd.start_read) begin
         limit_ff <= read_limit;
         cur_ff   <= oldest_ff;
         avail_ff <= fill_ff;
         sent_ff  <= '0;
      end
      if (cmd.issue_rd) begin
         cur_ff <= olrb_pkg::advance(cur_ff);
      end
      if (cmd.skip_upd) begin
         avail_ff <= avail_ff - olrb_pkg::CNT_W'(1);
      end
      if (cmd.clamp) begin
         if ({{(olrb_pkg::LIMIT_W - olrb_pkg::CNT_W){1'b0}}, avail_ff} > limit_m1) begin
            remain_ff <= limit_m1[olrb_pkg::CNT_W-1:0];
         end else begin
            remain_ff <= avail_ff;
         end
      end
      if (cmd.load_data) begin
         remain_ff <= remain_ff - olrb_pkg::CNT_W'(1);
         sent_ff   <= sent_ff + olrb_pkg::COUNT_W'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_err) begin
         out_byte_ff   <= olrb_pkg::NUL_CODE;
         out_last_ff   <= 1'b1;
         out_status_ff <= olrb_pkg::STATUS_BAD_LIMIT;
         out_count_ff  <= '0;
      end else if (cmd.load_data) begin
         out_byte_ff   <= rd_data_ff;
         out_last_ff   <= 1'b0;
         out_status_ff <= olrb_pkg::STATUS_OK;
         out_count_ff  <= '0;
      end else if (cmd.load_term) begin
         out_byte_ff   <= olrb_pkg::NUL_CODE;
         out_last_ff   <= 1'b1;
         out_status_ff <= olrb_pkg::STATUS_OK;
         out_count_ff  <= sent_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {{(olrb_pkg::RSP_DATA_W - olrb_pkg::BYTE_W - olrb_pkg::COUNT_W){1'b0}},
                        out_count_ff, out_byte_ff};

endmodule

// ===== rtl/core/overwriting_log_ring_buffer_top.sv =====
`timescale 1ns / 1ps

// Byte log ring buffer of 64 entries that overwrites its oldest byte when full.
// A put (req_tuser 0) is taken from idle, so puts stream at one per cycle while no read
// is in progress. A read (req_tuser 1) walks the store through the single registered read
// port of the log memory: a start step, a read and a check for each byte skipped up to the
// first newline when the store is full, a clamp and a first read, then one data byte per
// cycle unless rsp_tready stalls and a terminator transfer marked rsp_tlast that carries
// the count; a read limit of zero gives one error transfer. No new request is taken while
// a read is in progress. rsp_tready stalls hold the output register and the read walk.

module overwriting_log_ring_buffer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [olrb_pkg::REQ_DATA_W-1:0] req_tdata,  // put_byte[7:0], read_limit[23:8]
   input  logic                            req_tuser,  // req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [olrb_pkg::RSP_DATA_W-1:0] rsp_tdata,  // data_byte[7:0], copied_count[13:8]
   output logic                            rsp_tlast,  // last_flag
   output logic                            rsp_tuser   // status
);

   olrb_pkg::cmd_type  cmd;
   olrb_pkg::stat_type stat;

   olrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_type   (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   olrb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== bench/overwriting_log_ring_buffer_top_test.sv =====
`timescale 1ns / 1ps

module overwriting_log_ring_buffer_top_test;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [olrb_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [olrb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            rsp_tuser;

   // no idling on either side while set
   bit steady;
   int sent_items;

   typedef struct {
      logic [olrb_pkg::BYTE_W-1:0]  data_byte;
      logic                         last_flag;
      logic                         status;
      logic [olrb_pkg::COUNT_W-1:0] copied_count;
   } log_result_type;

   class log_scoreboard_type;
      logic [olrb_pkg::BYTE_W-1:0] store [olrb_pkg::BUFFER_DEPTH];
      logic [olrb_pkg::PTR_W-1:0]  oldest;
      logic [olrb_pkg::PTR_W-1:0]  wr_pos;
      int unsigned                 fill;
      log_result_type              pending [$];
      int                          errors;

      function new();
         foreach (store[i]) store[i] = '0;
         store[0] = olrb_pkg::NEWLINE_CODE;
         oldest   = '0;
         wr_pos   = olrb_pkg::PTR_W'(1);
         fill     = 1;
         errors   = 0;
      endfunction

      function logic [olrb_pkg::PTR_W-1:0] next_slot(logic [olrb_pkg::PTR_W-1:0] p);
         return (p == olrb_pkg::PTR_W'(olrb_pkg::BUFFER_DEPTH - 1)) ?
                '0 : p + olrb_pkg::PTR_W'(1);
      endfunction

      function void push_result(logic [olrb_pkg::BYTE_W-1:0] b, logic l, logic s,
                                logic [olrb_pkg::COUNT_W-1:0] c);
         log_result_type r;
         r.data_byte    = b;
         r.last_flag    = l;
         r.status       = s;
         r.copied_count = c;
         pending.push_back(r);
      endfunction

      function void note_request(logic kind, logic [olrb_pkg::BYTE_W-1:0] b,
                                 logic [olrb_pkg::LIMIT_W-1:0] lim);
         logic [olrb_pkg::PTR_W-1:0] pos;
         int unsigned                avail;
         int unsigned                skipped;
         bit                         hit_nl;
         if (kind == olrb_pkg::REQ_PUT) begin
            store[wr_pos] = b;
            wr_pos = next_slot(wr_pos);
            if (fill >= olrb_pkg::BUFFER_DEPTH) begin
               oldest = next_slot(oldest);
            end else begin
               fill++;
            end
            return;
         end
         if (lim == '0) begin
            push_result(olrb_pkg::NUL_CODE, 1'b1, olrb_pkg::STATUS_BAD_LIMIT, '0);
            return;
         end
         pos   = oldest;
         avail = fill;
         // a full store starts after the first line break
         if (avail == olrb_pkg::BUFFER_DEPTH) begin
            skipped = 0;
            hit_nl  = 0;
            while (skipped < avail && !hit_nl) begin
               hit_nl = (store[pos] == olrb_pkg::NEWLINE_CODE);
               pos = next_slot(pos);
               skipped++;
            end
            avail -= skipped;
         end
         if (avail > lim - 1) avail = lim - 1;
         for (int n = 0; n < avail; n++) begin
            push_result(store[pos], 1'b0, olrb_pkg::STATUS_OK, '0);
            pos = next_slot(pos);
         end
         push_result(olrb_pkg::NUL_CODE, 1'b1, olrb_pkg::STATUS_OK,
                     olrb_pkg::COUNT_W'(avail));
      endfunction

      function void check_result(logic [olrb_pkg::RSP_DATA_W-1:0] tdata, logic tlast,
                                 logic tuser);
         log_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected result transfer: tdata %0h tlast %0b tuser %0b",
                   tdata, tlast, tuser);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (tdata[7:0] !== e.data_byte) begin
            $error("data_byte expected %0h got %0h", e.data_byte, tdata[7:0]);
            errors++;
         end
         if (tdata[13:8] !== e.copied_count) begin
            $error("copied_count expected %0d got %0d", e.copied_count, tdata[13:8]);
            errors++;
         end
         if (tlast !== e.last_flag) begin
            $error("last_flag expected %0b got %0b", e.last_flag, tlast);
            errors++;
         end
         if (tuser !== e.status) begin
            $error("status expected %0b got %0b", e.status, tuser);
            errors++;
         end
      endfunction
   endclass

   log_scoreboard_type ring_model = new();

   overwriting_log_ring_buffer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // result side: check each transfer, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         ring_model.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
      rsp_tready <= steady || ($urandom_range(99) >= 21);
   end

   task automatic send_item(input logic kind, input logic [olrb_pkg::BYTE_W-1:0] b,
                            input logic [olrb_pkg::LIMIT_W-1:0] lim);
      while (!steady && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {lim, b};
      do @(posedge clock); while (!req_tready);
      ring_model.note_request(kind, b, lim);
      sent_items++;
      steady = (sent_items >= 90 && sent_items < 130);
   endtask

   task automatic put_byte(input logic [olrb_pkg::BYTE_W-1:0] b);
      send_item(olrb_pkg::REQ_PUT, b, olrb_pkg::LIMIT_W'($urandom));
   endtask

   task automatic read_log(input logic [olrb_pkg::LIMIT_W-1:0] lim);
      send_item(olrb_pkg::REQ_READ, olrb_pkg::BYTE_W'($urandom), lim);
   endtask

   function automatic logic [olrb_pkg::LIMIT_W-1:0] pick_limit();
      case ($urandom_range(9))
         0:       return '0;
         1:       return olrb_pkg::LIMIT_W'(1);
         2:       return olrb_pkg::LIMIT_W'(2);
         3, 4:    return olrb_pkg::LIMIT_W'($urandom_range(3, 70));
         5:       return '1;
         default: return olrb_pkg::LIMIT_W'($urandom);
      endcase
   endfunction

   initial begin
      int burst;
      int nl_pct;
      int seq;
      logic [olrb_pkg::BYTE_W-1:0] b;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= olrb_pkg::REQ_PUT;
      rsp_tready <= 1'b0;
      steady     = 0;
      sent_items = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part
      read_log('0);
      read_log(olrb_pkg::LIMIT_W'(1));
      read_log('1);
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(olrb_pkg::NEWLINE_CODE);
      put_byte(8'h55);
      read_log(olrb_pkg::LIMIT_W'(2));
      read_log(olrb_pkg::LIMIT_W'(3));
      read_log(16'h8000);
      read_log('1);
      put_byte(8'hAA);
      read_log(olrb_pkg::LIMIT_W'(5));

      // random part: bursts of puts, each followed by a read
      seq = 0;
      while (sent_items < 170) begin
         // first burst overfills the store with no line break at all
         burst = (seq == 0) ? 70 : $urandom_range(1, 24);
         case ($urandom_range(2))
            0:       nl_pct = 0;
            1:       nl_pct = 5;
            default: nl_pct = 25;
         endcase
         if (seq == 0) nl_pct = 0;
         repeat (burst) begin
            b = olrb_pkg::BYTE_W'($urandom);
            if (b == olrb_pkg::NEWLINE_CODE) b = 8'h0B;
            if ($urandom_range(99) < nl_pct) b = olrb_pkg::NEWLINE_CODE;
            put_byte(b);
         end
         read_log(pick_limit());
         if ($urandom_range(3) == 0) read_log(pick_limit());
         seq++;
      end
      req_tvalid <= 1'b0;

      while (ring_model.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (ring_model.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/olrb_pkg.sv
rtl/core/olrb_ctrl.sv
rtl/core/olrb_datapath.sv
rtl/core/overwriting_log_ring_buffer_top.sv
bench/overwriting_log_ring_buffer_top_test.sv
